// File: rtl/pciq_pkg.sv
`timescale 1ns / 1ps
// shared types and widths for the convex quad hit test
// no dependencies; imported by every module of the block
package pciq_pkg;

  // coordinate width of every input field
  localparam int COORD_BITS = 16;
  // width of a coordinate difference and of one cross product
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  typedef logic [1:0] corner_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  // the four corners of one word, index 0 in the low slot
  typedef point_t [3:0] quad_t;

  // named corners picked out of the quad
  typedef struct packed {
    corner_idx_t li;
    corner_idx_t ri;
    corner_idx_t ti;
    corner_idx_t bi;
  } corner_sel_t;

  // operands of one edge test
  typedef struct packed {
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [DIFF_BITS-1:0] t;
    logic signed [DIFF_BITS-1:0] e;
    logic signed [DIFF_BITS-1:0] dx;
  } edge_op_t;

  // outcome of one edge test, both false on a zero-width edge
  typedef struct packed {
    logic gt;
    logic lt;
  } side_t;

endpackage

// File: rtl/pciq_rank.sv
`timescale 1ns / 1ps
// two pipeline stages that rank the corners: leftmost/rightmost, then top/bottom
// depends on pciq_pkg
module pciq_rank
  import pciq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  quad_t       quad_i,
  input  point_t      query_i,
  output logic        valid_o,
  output quad_t       quad_o,
  output point_t      query_o,
  output corner_sel_t sel_o
);

  logic        v1_q, v2_q;
  quad_t       quad1_q, quad2_q;
  point_t      query1_q, query2_q;
  corner_idx_t li_d, ri_d, li_q, ri_q;
  corner_idx_t ti_d, bi_d;
  corner_sel_t sel_q;

  // leftmost and rightmost with their tie rules
  always_comb begin
    li_d = '0;
    ri_d = '0;
    for (int i = 1; i < 4; i++) begin
      if (quad_i[i].x < quad_i[li_d].x ||
          (quad_i[i].x == quad_i[li_d].x && quad_i[i].y > quad_i[li_d].y)) begin
        li_d = corner_idx_t'(i);
      end
      if (quad_i[i].x > quad_i[ri_d].x ||
          (quad_i[i].x == quad_i[ri_d].x && quad_i[i].y < quad_i[ri_d].y)) begin
        ri_d = corner_idx_t'(i);
      end
    end
  end

  // first least-y and first greatest-y among the remaining corners
  always_comb begin
    logic t_found;
    logic b_found;
    t_found = 1'b0;
    b_found = 1'b0;
    ti_d    = '0;
    bi_d    = '0;
    for (int i = 0; i < 4; i++) begin
      if (corner_idx_t'(i) != li_q && corner_idx_t'(i) != ri_q) begin
        if (!t_found || quad1_q[i].y < quad1_q[ti_d].y) begin
          ti_d = corner_idx_t'(i);
        end
        if (!b_found || quad1_q[i].y > quad1_q[bi_d].y) begin
          bi_d = corner_idx_t'(i);
        end
        t_found = 1'b1;
        b_found = 1'b1;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    quad1_q  <= quad_i;
    query1_q <= query_i;
    li_q     <= li_d;
    ri_q     <= ri_d;
    quad2_q  <= quad1_q;
    query2_q <= query1_q;
    sel_q    <= '{li: li_q, ri: ri_q, ti: ti_d, bi: bi_d};
  end

  assign valid_o = v2_q;
  assign quad_o  = quad2_q;
  assign query_o = query2_q;
  assign sel_o   = sel_q;

  // top and bottom never reuse the leftmost or rightmost corner
  a_top_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (sel_q.ti != sel_q.li && sel_q.ti != sel_q.ri))
    else $error("top corner collides with an extreme corner");
  a_bot_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (sel_q.bi != sel_q.li && sel_q.bi != sel_q.ri))
    else $error("bottom corner collides with an extreme corner");
  a_v2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(valid_i, 2))
    else $error("rank stage valid without an input word");

endmodule

// File: rtl/pciq_setup.sv
`timescale 1ns / 1ps
// one pipeline stage: box reject and choice of the upper and lower edge
// depends on pciq_pkg
module pciq_setup
  import pciq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  quad_t       quad_i,
  input  point_t      query_i,
  input  corner_sel_t sel_i,
  output logic        valid_o,
  output logic        outside_o,
  output edge_op_t    up_op_o,
  output edge_op_t    dn_op_o
);

  point_t   lc, rc, tc, bc;
  point_t   up_a, up_b, dn_a, dn_b;
  logic     outside_d, outside_q;
  edge_op_t up_d, dn_d, up_q, dn_q;
  logic     valid_q;

  // named corners
  assign lc = quad_i[sel_i.li];
  assign rc = quad_i[sel_i.ri];
  assign tc = quad_i[sel_i.ti];
  assign bc = quad_i[sel_i.bi];

  // extreme box
  assign outside_d = (query_i.x < lc.x) || (query_i.x > rc.x) ||
                     (query_i.y < tc.y) || (query_i.y > bc.y);

  // edge that covers the query x, upper and lower
  assign up_a = (query_i.x <= tc.x) ? lc : tc;
  assign up_b = (query_i.x <= tc.x) ? tc : rc;
  assign dn_a = (query_i.x <= bc.x) ? lc : bc;
  assign dn_b = (query_i.x <= bc.x) ? bc : rc;

  // differences for the cross products
  always_comb begin
    up_d.dy = DIFF_BITS'(up_b.y) - DIFF_BITS'(up_a.y);
    up_d.t  = DIFF_BITS'(query_i.x) - DIFF_BITS'(up_a.x);
    up_d.e  = DIFF_BITS'(query_i.y) - DIFF_BITS'(up_a.y);
    up_d.dx = DIFF_BITS'(up_b.x) - DIFF_BITS'(up_a.x);
    dn_d.dy = DIFF_BITS'(dn_b.y) - DIFF_BITS'(dn_a.y);
    dn_d.t  = DIFF_BITS'(query_i.x) - DIFF_BITS'(dn_a.x);
    dn_d.e  = DIFF_BITS'(query_i.y) - DIFF_BITS'(dn_a.y);
    dn_d.dx = DIFF_BITS'(dn_b.x) - DIFF_BITS'(dn_a.x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    outside_q <= outside_d;
    up_q      <= up_d;
    dn_q      <= dn_d;
  end

  assign valid_o   = valid_q;
  assign outside_o = outside_q;
  assign up_op_o   = up_q;
  assign dn_op_o   = dn_q;

  // a point inside the box never sits left of its chosen edges
  a_up_t_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !outside_q) |-> (up_q.t >= 0 && dn_q.t >= 0))
    else $error("query left of its edge start inside the box");
  a_up_e_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !outside_q) |-> (up_q.dx >= up_q.t && dn_q.dx >= dn_q.t))
    else $error("query beyond its edge end inside the box");
  a_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(valid_i))
    else $error("setup stage valid without a word");

endmodule

// File: rtl/pciq_side.sv
`timescale 1ns / 1ps
// two pipeline stages for one edge: cross products, then exact compare
// depends on pciq_pkg
module pciq_side
  import pciq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  edge_op_t op_i,
  output logic     valid_o,
  output side_t    side_o
);

  logic signed [PROD_BITS-1:0] p1_d, p2_d, p1_q, p2_q;
  logic  dx_pos_q;
  logic  v1_q, v2_q;
  side_t side_d, side_q;

  // both products of the cross multiplication
  assign p1_d = PROD_BITS'(op_i.dy) * PROD_BITS'(op_i.t);
  assign p2_d = PROD_BITS'(op_i.e) * PROD_BITS'(op_i.dx);

  // zero or backward width never decides
  assign side_d.gt = dx_pos_q && (p1_q > p2_q);
  assign side_d.lt = dx_pos_q && (p1_q < p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    dx_pos_q <= (op_i.dx > 0);
    side_q   <= side_d;
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;

  // above and below are exclusive
  a_side_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> !(side_q.gt && side_q.lt))
    else $error("edge reports both above and below");
  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !dx_pos_q) |=> (!side_q.gt && !side_q.lt))
    else $error("zero-width edge rejected a point");
  a_side_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(valid_i, 2))
    else $error("edge result valid without an operand word");

endmodule

// File: rtl/point_in_convex_quad_test.sv
`timescale 1ns / 1ps
// top level of the convex quad hit test
// depends on pciq_pkg, pciq_rank, pciq_setup, pciq_side
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------
//   in        start_i / busy_o   corner0..3 x/y, query_x/y (16-bit signed)
//   out       done_o (strobe)    inside_res_o
//
// an accepted word reaches its done_o strobe through the five register
// stages: two corner ranking, edge setup, multiply, compare.
// a new word is taken every cycle; busy_o stays low.
// reset clears only the valid bits; words in flight are dropped.
// results cannot be held off, so the pipeline never stalls.
module point_in_convex_quad_test
  import pciq_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] corner0_x_i,
  input  logic signed [COORD_BITS-1:0] corner0_y_i,
  input  logic signed [COORD_BITS-1:0] corner1_x_i,
  input  logic signed [COORD_BITS-1:0] corner1_y_i,
  input  logic signed [COORD_BITS-1:0] corner2_x_i,
  input  logic signed [COORD_BITS-1:0] corner2_y_i,
  input  logic signed [COORD_BITS-1:0] corner3_x_i,
  input  logic signed [COORD_BITS-1:0] corner3_y_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  output logic                         done_o,
  output logic                         inside_res_o
);

  quad_t       quad_in;
  point_t      query_in;
  logic        accept;
  logic        rk_valid, su_valid, up_valid, dn_valid;
  quad_t       rk_quad;
  point_t      rk_query;
  corner_sel_t rk_sel;
  logic        su_outside;
  edge_op_t    up_op, dn_op;
  side_t       up_side, dn_side;
  logic        out4_q, out5_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // gather the input word
  assign quad_in[0] = '{x: corner0_x_i, y: corner0_y_i};
  assign quad_in[1] = '{x: corner1_x_i, y: corner1_y_i};
  assign quad_in[2] = '{x: corner2_x_i, y: corner2_y_i};
  assign quad_in[3] = '{x: corner3_x_i, y: corner3_y_i};
  assign query_in   = '{x: query_x_i, y: query_y_i};

  pciq_rank u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .quad_i  (quad_in),
    .query_i (query_in),
    .valid_o (rk_valid),
    .quad_o  (rk_quad),
    .query_o (rk_query),
    .sel_o   (rk_sel)
  );

  pciq_setup u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rk_valid),
    .quad_i    (rk_quad),
    .query_i   (rk_query),
    .sel_i     (rk_sel),
    .valid_o   (su_valid),
    .outside_o (su_outside),
    .up_op_o   (up_op),
    .dn_op_o   (dn_op)
  );

  pciq_side u_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (su_valid),
    .op_i    (up_op),
    .valid_o (up_valid),
    .side_o  (up_side)
  );

  pciq_side u_dn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (su_valid),
    .op_i    (dn_op),
    .valid_o (dn_valid),
    .side_o  (dn_side)
  );

  // box reject travels alongside the edge stages
  always_ff @(posedge clk_i) begin
    out4_q <= su_outside;
    out5_q <= out4_q;
  end

  // upper edge rejects above, lower edge rejects below
  assign done_o       = up_valid;
  assign inside_res_o = up_valid && !out5_q && !up_side.gt && !dn_side.lt;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result without an accepted word five cycles back");
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    up_valid == dn_valid)
    else $error("upper and lower edge lanes out of step");
  a_inside_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_res_o |-> done_o)
    else $error("inside flag raised outside a result cycle");

endmodule
